>>> design/tdss_pkg.sv
// ----------------------------------------------------------------------------
// tdss_pkg: shared types and constants for the two-digit segment serialiser
// Segment code table, sequencer phases, register indexes and timing struct.
// ----------------------------------------------------------------------------
package tdss_pkg;

  // Bits per segment code and per display frame
  localparam int unsigned CodeBits  = 8;
  localparam int unsigned FrameBits = 2 * CodeBits;

  // Configuration register indexes
  localparam logic [1:0] REG_CLOCK_HALF_PERIOD = 2'd0;
  localparam logic [1:0] REG_LATCH_PULSE_WIDTH = 2'd1;

  // Configuration reset values
  localparam logic [15:0] CLOCK_HALF_PERIOD_RST = 16'd1;
  localparam logic [15:0] LATCH_PULSE_WIDTH_RST = 16'd50;

  // Serialiser phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SHIFT,
    PH_LATCH
  } phase_e;

  // Timing settings handed to the serialiser
  typedef struct packed {
    logic [15:0] clock_half_period;
    logic [15:0] latch_pulse_width;
  } timing_t;

  // Active-low segment code per symbol; out-of-range symbols show zero
  function automatic logic [CodeBits-1:0] seg_code(input logic [7:0] sym);
    logic [CodeBits-1:0] code;
    unique case (sym)
      8'd0:    code = 8'hC0;
      8'd1:    code = 8'hCF;
      8'd2:    code = 8'hA4;
      8'd3:    code = 8'hB0;
      8'd4:    code = 8'h99;
      8'd5:    code = 8'h92;
      8'd6:    code = 8'h82;
      8'd7:    code = 8'hF8;
      8'd8:    code = 8'h80;
      8'd9:    code = 8'h90;
      8'd10:   code = 8'h88;
      8'd11:   code = 8'h83;
      8'd12:   code = 8'hC6;
      8'd13:   code = 8'hA1;
      8'd14:   code = 8'h86;
      8'd15:   code = 8'h8E;
      8'd16:   code = 8'hFF; // blank
      8'd17:   code = 8'h7F; // decimal point
      default: code = 8'hC0;
    endcase
    return code;
  endfunction

endpackage

>>> design/two_digit_seven_segment_serializer.sv
// ----------------------------------------------------------------------------
// two_digit_seven_segment_serializer: two-digit display frame serialiser
// Maps two symbol indexes to segment codes and sends them out bit by bit,
// ones code first, marking the last bit for the latch pulse.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | in        | in_valid_i / in_stall_o   | tens_digit_i, ones_digit_i
//  out     | out       | out_valid_o / out_stall_i | serial_bit_o, latch_after_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One input beat yields 16 output beats. Each bit is paced by the
//  clock_half_period H (0 acts as 1) and the frame ends with a hold-off of
//  latch_pulse_width L (0 acts as 1). The next item is held in the input
//  register while a frame is shifting. Reset clears control state and sets
//  H = 1, L = 50; no clearing pass. Output stalls freeze the current bit;
//  input stalls only while both the input register and the serialiser are
//  occupied.
// ----------------------------------------------------------------------------
module two_digit_seven_segment_serializer
  import tdss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  tens_digit_i,
  input  logic [7:0]  ones_digit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        serial_bit_o,
  output logic        latch_after_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  timing_t              timing_q;
  logic                 full_q;
  logic [7:0]           tens_q;
  logic [7:0]           ones_q;
  logic                 accept;
  logic                 load;
  logic                 free;
  logic [FrameBits-1:0] frame;

  // Configuration registers, writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.clock_half_period <= CLOCK_HALF_PERIOD_RST;
      timing_q.latch_pulse_width <= LATCH_PULSE_WIDTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CLOCK_HALF_PERIOD: timing_q.clock_half_period <= cfg_data_i;
        REG_LATCH_PULSE_WIDTH: timing_q.latch_pulse_width <= cfg_data_i;
        default: ; // unknown index ignored
      endcase
    end
  end

  // Input register
  assign load       = full_q && free;
  assign in_stall_o = full_q && !free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= accept || (full_q && !load);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tens_q <= tens_digit_i;
      ones_q <= ones_digit_i;
    end
  end

  // Segment lookup: ones code goes out first
  assign frame = {seg_code(ones_q), seg_code(tens_q)};

  tdss_shifter u_shifter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .timing_i      (timing_q),
    .load_i        (load),
    .frame_i       (frame),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .serial_bit_o  (serial_bit_o),
    .latch_after_o (latch_after_o)
  );

  // A held item is never dropped before it is loaded
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q && !load) |=> full_q)
    else $error("held item lost");

  // Held digits stay put until loaded
  a_hold_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q && !load) |=> ($stable(tens_q) && $stable(ones_q)))
    else $error("held digits changed");

  // Nothing is loaded from an empty input register
  a_load_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> full_q)
    else $error("load from empty input register");

endmodule

>>> design/tdss_shifter.sv
// ----------------------------------------------------------------------------
// tdss_shifter: paced frame serialiser
// Emits a 16-bit frame MSB first, one beat per bit, each bit paced by the
// shift-clock half period, then holds off for the latch pulse width.
// ----------------------------------------------------------------------------
module tdss_shifter
  import tdss_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  timing_t              timing_i,
  input  logic                 load_i,
  input  logic [FrameBits-1:0] frame_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 serial_bit_o,
  output logic                 latch_after_o
);

  localparam int unsigned CntW = $clog2(FrameBits);
  localparam logic [CntW-1:0] LastBit = CntW'(FrameBits - 1);

  phase_e                phase_q, phase_d;
  logic [CntW-1:0]       cnt_q;
  logic [FrameBits-1:0]  shift_q;
  logic [15:0]           pace_q;
  logic [15:0]           limit;
  logic                  pace_hit;
  logic                  beat;
  logic                  last;

  // Pacing: wait out the half period per bit, or the latch width after the frame
  assign limit    = (phase_q == PH_LATCH) ? timing_i.latch_pulse_width
                                          : timing_i.clock_half_period;
  assign pace_hit = ({1'b0, pace_q} + 17'd1) >= {1'b0, limit};
  assign beat     = out_valid_o && !out_stall_i;
  assign last     = (cnt_q == LastBit);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (load_i) phase_d = PH_SHIFT;
      end
      PH_SHIFT: begin
        if (beat && last) phase_d = PH_LATCH;
      end
      PH_LATCH: begin
        if (pace_hit) phase_d = load_i ? PH_SHIFT : PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    free_o        = (phase_q == PH_IDLE) || ((phase_q == PH_LATCH) && pace_hit);
    out_valid_o   = (phase_q == PH_SHIFT) && pace_hit;
    serial_bit_o  = shift_q[FrameBits-1];
    latch_after_o = last;
  end

  // Phase, bit count and pace counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      pace_q  <= '0;
    end else begin
      phase_q <= phase_d;
      if (load_i) begin
        cnt_q  <= '0;
        pace_q <= '0;
      end else if (beat) begin
        cnt_q  <= cnt_q + 1'b1;
        pace_q <= '0;
      end else if (!pace_hit) begin
        pace_q <= pace_q + 16'd1;
      end
    end
  end

  // Frame shift register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      shift_q <= frame_i;
    end else if (beat) begin
      shift_q <= {shift_q[FrameBits-2:0], 1'b0};
    end
  end

  // A frame is loaded only when the serialiser can take it
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("frame loaded while serialiser busy");

  // The marked last beat always leads into the latch hold-off
  a_last_to_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && latch_after_o) |=> (phase_q == PH_LATCH))
    else $error("latch phase not entered after last bit");

  // A new frame starts from its first bit
  a_load_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (cnt_q == '0) && (phase_q == PH_SHIFT))
    else $error("frame did not start at bit zero");

endmodule

>>> bench/two_digit_seven_segment_serializer_test.sv
// ----------------------------------------------------------------------------
// two_digit_seven_segment_serializer_test: self-checking bench for the
// two-digit segment serialiser
// Feeds digit pairs, models the segment lookup and the 16-beat frame order,
// and checks every output beat in order while both sides idle and stall at
// random. Timing registers are moved through small values and both extremes
// between phases.
// ----------------------------------------------------------------------------
module two_digit_seven_segment_serializer_test;
  import tdss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned NUM_ROWS    = 20;
  localparam int unsigned NUM_GLYPHS  = 18;

  // Indexes past the register map; writes to them are dropped by the block
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic serial_bit;
    logic latch_after;
  } seg_beat_t;

  // Directed row: digits, whether the frame is typed in, and that frame
  typedef struct packed {
    logic [7:0]  tens;
    logic [7:0]  ones;
    logic        typed;
    logic [15:0] frame;
  } digit_row_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  tens_digit_i = 8'd0;
  logic [7:0]  ones_digit_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        serial_bit_o;
  logic        latch_after_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i  = REG_CLOCK_HALF_PERIOD;
  logic [15:0] cfg_data_i   = 16'd0;

  // Frames are {ones code, tens code}, sent MSB first
  digit_row_t directed_rows [NUM_ROWS] = '{
    '{8'd0,   8'd0,   1'b1, 16'hC0C0},
    '{8'd255, 8'd255, 1'b1, 16'hC0C0},
    '{8'd18,  8'd18,  1'b1, 16'hC0C0},
    '{8'd16,  8'd17,  1'b1, 16'h7FFF},
    '{8'd17,  8'd16,  1'b1, 16'hFF7F},
    '{8'd8,   8'd8,   1'b1, 16'h8080},
    '{8'd17,  8'd255, 1'b1, 16'hC07F},
    '{8'd16,  8'd16,  1'b1, 16'hFFFF},
    '{8'd1,   8'd2,   1'b0, 16'h0000},
    '{8'd3,   8'd4,   1'b0, 16'h0000},
    '{8'd5,   8'd6,   1'b0, 16'h0000},
    '{8'd7,   8'd9,   1'b0, 16'h0000},
    '{8'd10,  8'd11,  1'b0, 16'h0000},
    '{8'd12,  8'd13,  1'b0, 16'h0000},
    '{8'd14,  8'd15,  1'b0, 16'h0000},
    '{8'd15,  8'd14,  1'b0, 16'h0000},
    '{8'd9,   8'd1,   1'b0, 16'h0000},
    '{8'h55,  8'hAA,  1'b0, 16'h0000},
    '{8'hAA,  8'h55,  1'b0, 16'h0000},
    '{8'd19,  8'd128, 1'b0, 16'h0000}
  };

  // Active-low segment patterns: hex digits, then blank and point
  logic [7:0] glyph_codes [NUM_GLYPHS] = '{
    8'hC0, 8'hCF, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90,
    8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hFF, 8'h7F
  };

  seg_beat_t   pending_bits [$];
  int unsigned mismatches  = 0;
  int unsigned beat_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;

  // Shadow of the latch pulse width; only the settle time depends on it
  logic [15:0] latch_width_q = LATCH_PULSE_WIDTH_RST;

  two_digit_seven_segment_serializer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .tens_digit_i (tens_digit_i),
    .ones_digit_i (ones_digit_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .serial_bit_o (serial_bit_o),
    .latch_after_o(latch_after_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Segment pattern for one symbol; unknown symbols show zero
  function automatic logic [7:0] glyph_for(input logic [7:0] digit);
    if (digit < NUM_GLYPHS) begin
      return glyph_codes[digit[4:0]];
    end
    return glyph_codes[0];
  endfunction

  function automatic logic [15:0] frame_for(input logic [7:0] tens, input logic [7:0] ones);
    return {glyph_for(ones), glyph_for(tens)};
  endfunction

  // Mostly real symbols, sometimes anything the field can carry
  function automatic logic [7:0] pick_digit();
    if ($urandom_range(9) < 7) begin
      return 8'($urandom_range(NUM_GLYPHS - 1));
    end
    return 8'($urandom_range(255));
  endfunction

  // Expand a frame into its 16 beats; latch mark on the last one
  task automatic queue_frame(input logic [15:0] frame);
    for (int k = 15; k >= 0; k--) begin
      pending_bits.push_back('{serial_bit: frame[k], latch_after: (k == 0)});
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at beat %0d: %s", beat_count, what);
    end
  endtask

  // One input beat, after a random idle gap
  task automatic send_digits(input logic [7:0] tens, input logic [7:0] ones,
                             input logic typed, input logic [15:0] typed_frame);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    tens_digit_i <= tens;
    ones_digit_i <= ones;
    do @(posedge clk_i); while (in_stall_o);
    queue_frame(typed ? typed_frame : frame_for(tens, ones));
  endtask

  task automatic run_random(input int unsigned count, input int unsigned sender_pct,
                            input int unsigned receiver_pct);
    idle_pct  = sender_pct;
    stall_pct = receiver_pct;
    repeat (count) send_digits(pick_digit(), pick_digit(), 1'b0, 16'h0000);
  endtask

  // Drain all beats, then let the latch hold-off run out
  task automatic settle();
    while (pending_bits.size() != 0) @(posedge clk_i);
    repeat (int'(latch_width_q) + 8) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last write
  task automatic write_register(input logic [1:0] index, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == REG_LATCH_PULSE_WIDTH) begin
      latch_width_q = data;
    end
  endtask

  task automatic program_timing(input logic [15:0] half_period, input logic [15:0] latch_width);
    write_register(REG_CLOCK_HALF_PERIOD, half_period);
    write_register(REG_LATCH_PULSE_WIDTH, latch_width);
    write_register(REG_SPARE_A, 16'($urandom));
    write_register(REG_SPARE_B, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Output checker: each accepted beat against the oldest expectation
  always @(posedge clk_i) begin
    seg_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bits.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, serial_bit %b latch_after %b",
                                  serial_bit_o, latch_after_o));
      end else begin
        want = pending_bits.pop_front();
        if (serial_bit_o !== want.serial_bit) begin
          report_mismatch($sformatf("serial_bit expected %b, got %b",
                                    want.serial_bit, serial_bit_o));
        end
        if (latch_after_o !== want.latch_after) begin
          report_mismatch($sformatf("latch_after expected %b, got %b",
                                    want.latch_after, latch_after_o));
        end
      end
      beat_count++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    digit_row_t row;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at reset timing, no idling
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = directed_rows[r];
      send_digits(row.tens, row.ones, row.typed, row.frame);
    end
    in_valid_i <= 1'b0;

    // Fastest timing, through every idling mix
    settle();
    program_timing(16'd1, 16'd1);
    run_random(110, 0, 0);
    run_random(110, 59, 0);
    run_random(110, 0, 59);
    run_random(110, 12, 12);
    in_valid_i <= 1'b0;

    // Small odd timings
    settle();
    program_timing(16'($urandom_range(2, 4)), 16'($urandom_range(2, 20)));
    run_random(40, 12, 12);
    in_valid_i <= 1'b0;

    // Zero half period, longest latch pulse
    idle_pct  = 0;
    stall_pct = 0;
    settle();
    program_timing(16'd0, 16'hFFFF);
    run_random(2, 0, 0);
    in_valid_i <= 1'b0;

    // Longest half period, zero latch pulse: one frame only
    settle();
    program_timing(16'hFFFF, 16'd0);
    run_random(1, 0, 0);
    in_valid_i <= 1'b0;

    // Back to the reset timing
    settle();
    program_timing(CLOCK_HALF_PERIOD_RST, LATCH_PULSE_WIDTH_RST);
    run_random(20, 12, 12);
    in_valid_i <= 1'b0;

    settle();
    if (mismatches == 0 && pending_bits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
design/tdss_pkg.sv
design/tdss_shifter.sv
design/two_digit_seven_segment_serializer.sv
bench/two_digit_seven_segment_serializer_test.sv
